// ===== rtl/vtd_pkg.sv =====
// ============================================================================
// Vertex tuple dedup package
// Shared sizes, payload structs and the token that travels along the
// compare-cell chain.
// ============================================================================
package vtd_pkg;

  // Field widths fixed by the payload format.
  localparam int INDEX_BITS = 24;
  localparam int KEY_BITS   = INDEX_BITS + 1;
  localparam int ID_BITS    = 10;

  // Table geometry: slot = row * CELL_COUNT + column.
  localparam int TABLE_DEPTH   = 1024;
  localparam int CELL_COUNT    = (TABLE_DEPTH < 32) ? TABLE_DEPTH : 32;
  localparam int ROW_COUNT     = (TABLE_DEPTH + CELL_COUNT - 1) / CELL_COUNT;
  localparam int CELL_BITS     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int ROW_BITS      = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int FILL_ROW_BITS = $clog2(ROW_COUNT + 1);
  localparam int COUNT_BITS    = $clog2(TABLE_DEPTH + 1);
  localparam int RET_BITS      = $clog2(ROW_COUNT + 1);

  // A key is the present flag over the index; an absent component is zero.
  typedef logic [KEY_BITS-1:0] key_t;

  typedef struct packed {
    key_t pos;
    key_t nrm;
    key_t uv;
  } entry_t;

  // Lookup token: one per table row, carrying the running match result.
  typedef struct packed {
    logic                 valid;
    logic [ROW_BITS-1:0]  row;
    entry_t               key;
    logic                 hit;
    logic [CELL_BITS-1:0] hit_cell;
  } token_t;

  // Next free slot, split into row and column.
  typedef struct packed {
    logic [FILL_ROW_BITS-1:0] row;
    logic [CELL_BITS-1:0]     col;
  } fill_t;

  // Table write broadcast to all cells.
  typedef struct packed {
    logic                 en;
    logic [ROW_BITS-1:0]  row;
    logic [CELL_BITS-1:0] col;
    entry_t               entry;
  } wr_t;

  typedef struct packed {
    logic                  new_mesh;
    logic [INDEX_BITS-1:0] pos_index;
    logic                  pos_present;
    logic [INDEX_BITS-1:0] normal_index;
    logic                  normal_present;
    logic [INDEX_BITS-1:0] uv_index;
    logic                  uv_present;
  } in_t;

  typedef struct packed {
    logic [ID_BITS-1:0] vertex_id;
    logic               is_new;
    logic               overflow;
  } out_t;

endpackage

// ===== rtl/vtd_cell.sv =====
// ============================================================================
// Vertex tuple dedup compare cell
// Holds one column of the table (one entry per row) and compares each
// passing token against the entry of the token's row.
// ============================================================================
module vtd_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [vtd_pkg::CELL_BITS-1:0] cell_idx_i,
  input  vtd_pkg::fill_t                fill_i,
  input  vtd_pkg::wr_t                  wr_i,
  input  vtd_pkg::token_t               tok_i,
  output vtd_pkg::token_t               tok_o
);
  import vtd_pkg::*;

  entry_t mem_q [ROW_COUNT];
  entry_t rd_q;
  token_t tok_a_q;
  token_t tok_b_d, tok_b_q;
  logic   slot_ok;
  logic   hit_now;

  // Column storage: written by the broadcast, read at the incoming row.
  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.col == cell_idx_i)) begin
      mem_q[wr_i.row] <= wr_i.entry;
    end
    rd_q <= mem_q[tok_i.row];
  end

  // Only slots below the fill pointer hold live entries.
  always_comb begin
    slot_ok = (FILL_ROW_BITS'(tok_a_q.row) < fill_i.row) ||
              ((FILL_ROW_BITS'(tok_a_q.row) == fill_i.row) &&
               (cell_idx_i < fill_i.col));
    hit_now = tok_a_q.valid && slot_ok && (rd_q == tok_a_q.key);
    tok_b_d = tok_a_q;
    if (hit_now) begin
      tok_b_d.hit      = 1'b1;
      tok_b_d.hit_cell = cell_idx_i;
    end
  end

  // Two stages per cell: one for the read, one for the compare.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_a_q.valid <= 1'b0;
      tok_b_q.valid <= 1'b0;
    end else begin
      tok_a_q <= tok_i;
      tok_b_q <= tok_b_d;
    end
  end

  assign tok_o = tok_b_q;

endmodule

// ===== rtl/vtd_ctrl.sv =====
// ============================================================================
// Vertex tuple dedup controller
// Takes a corner transaction, sends one token per table row down the cell
// chain, gathers the match result and appends a new triple on a miss.
// ============================================================================
module vtd_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  vtd_pkg::in_t    in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output vtd_pkg::out_t   out_data_o,
  output vtd_pkg::token_t tok_o,
  input  vtd_pkg::token_t tok_i,
  output vtd_pkg::fill_t  fill_o,
  output vtd_pkg::wr_t    wr_o
);
  import vtd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_RESULT = 4'b1000
  } state_e;

  localparam int SLOT_BITS = (COUNT_BITS > ID_BITS) ? COUNT_BITS : ID_BITS;

  function automatic key_t make_key(logic [INDEX_BITS-1:0] index, logic present);
    key_t key;
    key = present ? {1'b1, index} : '0;
    return key;
  endfunction

  state_e                   state_d, state_q;
  entry_t                   key_d, key_q;
  logic [ROW_BITS-1:0]      issue_row_d, issue_row_q;
  logic [RET_BITS-1:0]      ret_cnt_d, ret_cnt_q;
  logic                     hit_d, hit_q;
  logic [ROW_BITS-1:0]      hit_row_d, hit_row_q;
  logic [CELL_BITS-1:0]     hit_cell_d, hit_cell_q;
  logic [COUNT_BITS-1:0]    count_d, count_q;
  logic [FILL_ROW_BITS-1:0] fill_row_d, fill_row_q;
  logic [CELL_BITS-1:0]     fill_cell_d, fill_cell_q;
  logic                     out_valid_d, out_valid_q;
  out_t                     out_d, out_q;
  logic                     in_take;
  logic                     out_free;
  logic                     table_full;
  logic [SLOT_BITS-1:0]     hit_slot;

  assign in_take    = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign table_full = (count_q == COUNT_BITS'(TABLE_DEPTH));
  assign hit_slot   = SLOT_BITS'(SLOT_BITS'(hit_row_q) * SLOT_BITS'(CELL_COUNT)) +
                      SLOT_BITS'(hit_cell_q);

  // Token injection: one per row while scanning.
  always_comb begin
    tok_o          = '0;
    tok_o.valid    = (state_q == S_SCAN);
    tok_o.row      = issue_row_q;
    tok_o.key      = key_q;
    tok_o.hit      = 1'b0;
    tok_o.hit_cell = '0;
  end

  assign fill_o.row = fill_row_q;
  assign fill_o.col = fill_cell_q;

  // Sequencer, result gathering and table append.
  always_comb begin
    state_d     = state_q;
    key_d       = key_q;
    issue_row_d = issue_row_q;
    ret_cnt_d   = ret_cnt_q;
    hit_d       = hit_q;
    hit_row_d   = hit_row_q;
    hit_cell_d  = hit_cell_q;
    count_d     = count_q;
    fill_row_d  = fill_row_q;
    fill_cell_d = fill_cell_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    wr_o        = '0;
    wr_o.row    = fill_row_q[ROW_BITS-1:0];
    wr_o.col    = fill_cell_q;
    wr_o.entry  = key_q;

    // Collect returning tokens; at most one of them can carry a hit.
    if (tok_i.valid) begin
      ret_cnt_d = ret_cnt_q + RET_BITS'(1);
      if (tok_i.hit) begin
        hit_d      = 1'b1;
        hit_row_d  = tok_i.row;
        hit_cell_d = tok_i.hit_cell;
      end
    end

    case (state_q)
      S_IDLE: begin
        if (in_take) begin
          key_d.pos   = make_key(in_data_i.pos_index, in_data_i.pos_present);
          key_d.nrm   = make_key(in_data_i.normal_index, in_data_i.normal_present);
          key_d.uv    = make_key(in_data_i.uv_index, in_data_i.uv_present);
          issue_row_d = '0;
          ret_cnt_d   = '0;
          hit_d       = 1'b0;
          if (in_data_i.new_mesh) begin
            count_d     = '0;
            fill_row_d  = '0;
            fill_cell_d = '0;
          end
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (issue_row_q == ROW_BITS'(ROW_COUNT - 1)) begin
          state_d = S_DRAIN;
        end else begin
          issue_row_d = issue_row_q + ROW_BITS'(1);
        end
      end
      S_DRAIN: begin
        if (ret_cnt_q == RET_BITS'(ROW_COUNT)) begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          if (hit_q) begin
            out_d.vertex_id = ID_BITS'(hit_slot);
          end else if (table_full) begin
            out_d.overflow = 1'b1;
          end else begin
            out_d.vertex_id = ID_BITS'(count_q);
            out_d.is_new    = 1'b1;
            wr_o.en         = 1'b1;
            count_d         = count_q + COUNT_BITS'(1);
            if (fill_cell_q == CELL_BITS'(CELL_COUNT - 1)) begin
              fill_cell_d = '0;
              fill_row_d  = fill_row_q + FILL_ROW_BITS'(1);
            end else begin
              fill_cell_d = fill_cell_q + CELL_BITS'(1);
            end
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_cnt_q   <= '0;
      count_q     <= '0;
      fill_row_q  <= '0;
      fill_cell_q <= '0;
      out_valid_q <= 1'b0;
      issue_row_q <= '0;
      hit_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_cnt_q   <= ret_cnt_d;
      count_q     <= count_d;
      fill_row_q  <= fill_row_d;
      fill_cell_q <= fill_cell_d;
      out_valid_q <= out_valid_d;
      issue_row_q <= issue_row_d;
      hit_q       <= hit_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    hit_row_q  <= hit_row_d;
    hit_cell_q <= hit_cell_d;
    out_q      <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The fill pointer always names the slot given by the entry count.
  a_fill_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == COUNT_BITS'(COUNT_BITS'(fill_row_q) * COUNT_BITS'(CELL_COUNT)) +
               COUNT_BITS'(fill_cell_q))
    else $error("fill pointer out of step with entry count");

  // The entry count never passes the table depth.
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= COUNT_BITS'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // Every token has returned once the result is being formed.
  a_result_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESULT) |-> (ret_cnt_q == RET_BITS'(ROW_COUNT)) && !tok_i.valid)
    else $error("result formed while tokens still in the chain");

  // No token leaves the chain while the block is idle.
  a_no_stray_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !tok_i.valid)
    else $error("token returned with no lookup in flight");

  // A result is never both new and an overflow.
  a_result_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.is_new && out_q.overflow))
    else $error("result flagged both new and overflow");

endmodule

// ===== rtl/vertex_tuple_dedup.sv =====
// ============================================================================
// Vertex tuple dedup
// Maps (position, normal, texcoord) index triples of face corners to
// vertex ids, appending unseen triples to a table.
// ============================================================================
// Usage:
//   The input channel carries one face corner per transaction: three indices,
//   each with a present flag, and a new_mesh flag that empties the table
//   before the corner is looked up. The output channel returns one
//   transaction per corner: the vertex id, is_new when the triple was just
//   appended, and overflow (id 0) when the triple is unseen and the table
//   is full.
//   The table is a chain of CELL_COUNT compare cells, each holding one column
//   of ROW_COUNT entries. A lookup sends one token per row down the chain;
//   each cell has a read stage and a compare stage. The chain length and
//   the row count set how long a lookup takes, and one corner is handled at
//   a time: the next corner is accepted only after its result is formed.
//   The input is stalled for the whole lookup. A finished result sits in an
//   output register that a stalled receiver holds; the next lookup then waits
//   with its result until the receiver takes the earlier one.
//   Reset empties the table (entry count zero) and drops any result.
// ============================================================================
module vertex_tuple_dedup (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  vtd_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output vtd_pkg::out_t out_data_o
);
  import vtd_pkg::*;

  token_t chain [CELL_COUNT+1];
  fill_t  fill;
  wr_t    wr;

  // Sequencer and result register.
  vtd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .tok_o       (chain[0]),
    .tok_i       (chain[CELL_COUNT]),
    .fill_o      (fill),
    .wr_o        (wr)
  );

  // Row of compare cells; each token passes a read and a compare stage per cell.
  for (genvar c = 0; c < CELL_COUNT; c++) begin : g_cell
    vtd_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (CELL_BITS'(c)),
      .fill_i     (fill),
      .wr_i       (wr),
      .tok_i      (chain[c]),
      .tok_o      (chain[c+1])
    );
  end

endmodule
